// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the oscillator RTL.
// Defining ASSERT_OFF compiles every check away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_ALWAYS(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, clk, rst, prop, msg)
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

// ----- rtl/wti_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants of the wavetable oscillator.
// No dependencies; used by the controller, the datapath and the top level.
package wti_pkg;

  localparam int TABLE_BITS_DEF  = 12;
  localparam int PHASE_BITS_DEF  = 24;
  localparam int SAMPLE_BITS_DEF = 16;

  // Amplitude is an unsigned Q0.16 gain.
  localparam int AMP_BITS = 16;

  localparam logic [31:0]         PHASE_INC_RESET   = 32'd153791;
  localparam logic [AMP_BITS-1:0] AMP_RESET         = 16'd13107;
  localparam logic [31:0]         START_PHASE_RESET = 32'd0;

  // Request codes carried in tuser.
  localparam logic [1:0] REQ_SAMPLE  = 2'd0;
  localparam logic [1:0] REQ_WRITE   = 2'd1;
  localparam logic [1:0] REQ_RESTART = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] CFG_PHASE_INC   = 2'd0;
  localparam logic [1:0] CFG_AMPLITUDE   = 2'd1;
  localparam logic [1:0] CFG_START_PHASE = 2'd2;

  typedef enum logic [1:0] {
    ADDR_POS,
    ADDR_NEXT,
    ADDR_WRITE
  } addr_sel_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD_NEXT,
    S_MUL_FRAC,
    S_ADD,
    S_SCALE,
    S_EMIT
  } wti_state_t;

  typedef struct packed {
    addr_sel_t addr_sel;
    logic      ram_we;
    logic      restart;
    logic      latch_adv;
    logic      cap_v1;
    logic      cap_prod1;
    logic      step_phase;
    logic      cap_interp;
    logic      cap_scaled;
    logic      load_out;
  } wti_cmd_t;

  typedef struct packed {
    logic out_free;
  } wti_status_t;

endpackage

// ----- rtl/wti_ram.sv -----
`timescale 1ns / 1ps
// Generic single-port RAM with a registered read.
// No dependencies.
module wti_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ----- rtl/wti_datapath.sv -----
`timescale 1ns / 1ps
// Datapath of the oscillator: registers, phase accumulator, wave table,
// interpolation and gain. Depends on wti_pkg and wti_ram.
module wti_datapath import wti_pkg::*; #(
  parameter int TABLE_BITS  = TABLE_BITS_DEF,
  parameter int PHASE_BITS  = PHASE_BITS_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int IN_DATA_W   = 32,
  parameter int OUT_DATA_W  = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [IN_DATA_W-1:0]  s_tdata,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [1:0]            cfg_index,
  input  logic [PHASE_BITS-1:0] cfg_data,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,
  input  wti_cmd_t              cmd,
  output wti_status_t           status
);

  localparam int FRAC_BITS = PHASE_BITS - TABLE_BITS;
  localparam int PROD1_W   = SAMPLE_BITS + FRAC_BITS + 2;
  localparam int PROD2_W   = SAMPLE_BITS + AMP_BITS + 1;

  logic [PHASE_BITS-1:0] phase_inc;
  logic [AMP_BITS-1:0]   amplitude;
  logic [PHASE_BITS-1:0] start_phase;
  logic [PHASE_BITS-1:0] phase;
  logic                  adv;

  logic [TABLE_BITS-1:0]  wr_index;
  logic [SAMPLE_BITS-1:0] wr_value;
  logic [TABLE_BITS-1:0]  pos;
  logic [TABLE_BITS-1:0]  nxt;
  logic [FRAC_BITS-1:0]   frac;
  logic [TABLE_BITS-1:0]  ram_addr;
  logic [SAMPLE_BITS-1:0] ram_rdata;

  logic signed [SAMPLE_BITS-1:0] v1;
  logic signed [SAMPLE_BITS-1:0] v2;
  logic signed [SAMPLE_BITS:0]   diff;
  logic signed [PROD1_W-1:0]     prod1;
  logic signed [SAMPLE_BITS+1:0] step;
  logic signed [SAMPLE_BITS+1:0] interp_sum;
  logic signed [SAMPLE_BITS-1:0] interp;
  logic signed [PROD2_W-1:0]     prod2;
  logic signed [SAMPLE_BITS-1:0] sample_q;

  // Input word: advance, table_index, table_value from the lowest bit up.
  assign wr_index = s_tdata[TABLE_BITS:1];
  assign wr_value = s_tdata[TABLE_BITS+SAMPLE_BITS:TABLE_BITS+1];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_inc   <= PHASE_BITS'(PHASE_INC_RESET);
      amplitude   <= AMP_RESET;
      start_phase <= PHASE_BITS'(START_PHASE_RESET);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_PHASE_INC:   phase_inc   <= cfg_data;
        CFG_AMPLITUDE:   amplitude   <= cfg_data[AMP_BITS-1:0];
        CFG_START_PHASE: start_phase <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PHASE_BITS'(START_PHASE_RESET);
    end else if (cmd.restart) begin
      phase <= start_phase;
    end else if (cmd.step_phase && adv) begin
      phase <= phase + phase_inc;
    end
  end

  assign pos  = phase[PHASE_BITS-1:FRAC_BITS];
  assign nxt  = pos + 1'b1;
  assign frac = phase[FRAC_BITS-1:0];

  always_comb begin
    unique case (cmd.addr_sel)
      ADDR_POS:   ram_addr = pos;
      ADDR_NEXT:  ram_addr = nxt;
      ADDR_WRITE: ram_addr = wr_index;
      default:    ram_addr = pos;
    endcase
  end

  wti_ram #(
    .WIDTH(SAMPLE_BITS),
    .DEPTH(1 << TABLE_BITS)
  ) u_table (
    .clk  (clk),
    .we   (cmd.ram_we),
    .addr (ram_addr),
    .wdata(wr_value),
    .rdata(ram_rdata)
  );

  assign v2   = $signed(ram_rdata);
  assign diff = $signed({v2[SAMPLE_BITS-1], v2}) - $signed({v1[SAMPLE_BITS-1], v1});

  // The arithmetic shifts by taking upper bits give floor division.
  assign step       = prod1[PROD1_W-1:FRAC_BITS];
  assign interp_sum = $signed({{2{v1[SAMPLE_BITS-1]}}, v1}) + step;

  always_ff @(posedge clk) begin
    if (cmd.latch_adv) begin
      adv <= s_tdata[0];
    end
    if (cmd.cap_v1) begin
      v1 <= v2;
    end
    if (cmd.cap_prod1) begin
      prod1 <= diff * $signed({1'b0, frac});
    end
    if (cmd.cap_interp) begin
      interp <= interp_sum[SAMPLE_BITS-1:0];
    end
    if (cmd.cap_scaled) begin
      prod2 <= interp * $signed({1'b0, amplitude});
    end
    if (cmd.load_out) begin
      sample_q <= prod2[AMP_BITS+SAMPLE_BITS-1:AMP_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  assign m_tdata         = OUT_DATA_W'($unsigned(sample_q));
  assign status.out_free = !m_tvalid || m_tready;

endmodule

// ----- rtl/wti_ctrl.sv -----
`timescale 1ns / 1ps
// Controller of the oscillator: sequences table reads, arithmetic and output.
// Depends on wti_pkg and assert_macros.svh.
`include "assert_macros.svh"
module wti_ctrl import wti_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [1:0]  s_tuser,
  input  wti_status_t status,
  output wti_cmd_t    cmd
);

  wti_state_t state;
  wti_state_t state_next;
  logic       sample_accept;

  assign sample_accept = s_tvalid && s_tready && (s_tuser == REQ_SAMPLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    cmd        = '0;
    cmd.addr_sel = ADDR_POS;
    unique case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        // The read of the current entry starts in the same cycle a sample word arrives.
        if (s_tvalid) begin
          unique case (s_tuser)
            REQ_SAMPLE: begin
              cmd.latch_adv = 1'b1;
              state_next    = S_RD_NEXT;
            end
            REQ_WRITE: begin
              cmd.addr_sel = ADDR_WRITE;
              cmd.ram_we   = 1'b1;
            end
            REQ_RESTART: cmd.restart = 1'b1;
            default: ;
          endcase
        end
      end
      S_RD_NEXT: begin
        cmd.addr_sel = ADDR_NEXT;
        cmd.cap_v1   = 1'b1;
        state_next   = S_MUL_FRAC;
      end
      S_MUL_FRAC: begin
        // The fraction is used here, so the phase may step at this edge.
        cmd.cap_prod1  = 1'b1;
        cmd.step_phase = 1'b1;
        state_next     = S_ADD;
      end
      S_ADD: begin
        cmd.cap_interp = 1'b1;
        state_next     = S_SCALE;
      end
      S_SCALE: begin
        cmd.cap_scaled = 1'b1;
        state_next     = S_EMIT;
      end
      S_EMIT: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  `ASSERT_IMPLIES(a_load_free, clk, rst, cmd.load_out, status.out_free, "output overwritten")
  `ASSERT_NEXT(a_sample_start, clk, rst, sample_accept, state == S_RD_NEXT, "read not started")
  `ASSERT_IMPLIES(a_we_idle, clk, rst, cmd.ram_we, state == S_IDLE && s_tvalid, "stray write")
  `ASSERT_NEXT(a_scale_emit, clk, rst, state == S_SCALE, state == S_EMIT, "no emit after scale")

endmodule

// ----- rtl/wavetable_oscillator_interp.sv -----
`timescale 1ns / 1ps
// Wavetable oscillator with linear interpolation, top level.
// Depends on wti_pkg, wti_ctrl, wti_datapath and wti_ram.
//
// Usage:
//   Input words arrive on s_tvalid/s_tready; tuser carries the request kind:
//   sample, table write or phase restart. A table write stores one entry and
//   a restart reloads the phase from start_phase; neither produces an output.
//   A sample word produces one output word on m_tvalid/m_tready.
//   Registers (phase increment, amplitude, start phase) are written through
//   the cfg channel, which is always ready; write them only while idle.
//   A table write or a restart is taken while the controller is idle. A sample
//   word holds the controller through S_RD_NEXT, S_MUL_FRAC, S_ADD, S_SCALE
//   and S_EMIT, set by the two reads of the single-port wave table and the
//   two registered multiplies; m_tvalid rises as it leaves S_EMIT.
//   The output register lets the next word be accepted while a result waits;
//   if the receiver stalls, the following sample stops at its last step
//   until the output register frees up.
//   Reset sets the registers to their defaults and the phase to zero; the
//   wave table is not cleared and must be loaded before samples are taken.
module wavetable_oscillator_interp import wti_pkg::*; #(
  parameter int TABLE_BITS  = TABLE_BITS_DEF,
  parameter int PHASE_BITS  = PHASE_BITS_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  localparam int IN_DATA_W  = ((1 + TABLE_BITS + SAMPLE_BITS + 7) / 8) * 8,
  localparam int OUT_DATA_W = ((SAMPLE_BITS + 7) / 8) * 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // advance, table_index, table_value
  input  logic [1:0]            s_tuser,   // req_type
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [1:0]            cfg_index,
  input  logic [PHASE_BITS-1:0] cfg_data,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata    // sample
);

  wti_cmd_t    cmd;
  wti_status_t status;

  wti_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tuser (s_tuser),
    .status  (status),
    .cmd     (cmd)
  );

  wti_datapath #(
    .TABLE_BITS (TABLE_BITS),
    .PHASE_BITS (PHASE_BITS),
    .SAMPLE_BITS(SAMPLE_BITS),
    .IN_DATA_W  (IN_DATA_W),
    .OUT_DATA_W (OUT_DATA_W)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cmd      (cmd),
    .status   (status)
  );

endmodule
